[hdl/pmmp_pkg.sv]
`default_nettype none
package pmmp_pkg;

    localparam logic [29:0] PRIME = 30'd1000000009;

    typedef struct packed {
        logic [29:0] coef_a;
        logic [29:0] coef_b;
        logic        last_in;
    } in_beat_t;

    typedef struct packed {
        logic [29:0] product_coef;
        logic        last_out;
    } out_beat_t;

    function automatic logic [29:0] reduce_once(input logic [30:0] v);
        logic [30:0] d;
        d = v - {1'b0, PRIME};
        return (v >= {1'b0, PRIME}) ? d[29:0] : v[29:0];
    endfunction

endpackage
`default_nettype wire

[hdl/pmmp_mulmod.sv]
`default_nettype none
// Pipelined modular multiply: a*b mod PRIME in five stages.
// Barrett reduction: the quotient estimate comes from the top 31 bits of the
// product times floor(2^60/PRIME) and is at most two short, so the remainder
// fits in 32 bits and needs at most two subtractions of the prime.
module pmmp_mulmod
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic [29:0] a,
    input  wire logic [29:0] b,
    output logic [29:0]      p
);
    localparam logic [63:0] PR64   = 64'd1000000009;
    localparam logic [30:0] RECIP  = 31'(64'h1000_0000_0000_0000 / PR64);
    localparam logic [31:0] PR32   = 32'(PR64);
    localparam logic [31:0] PR32X2 = 32'(PR64 * 64'd2);

    logic [59:0] prod_reg;
    logic [30:0] q_reg;
    logic [31:0] lo1_reg;
    logic [31:0] lo2_reg;
    logic [31:0] qp_reg;
    logic [31:0] r_reg;
    logic [29:0] p_reg;

    logic [61:0] est;
    logic [31:0] r_next;
    logic [29:0] p_next;

    always_comb
    begin
        est    = {31'd0, prod_reg[59:29]} * {31'd0, RECIP};
        r_next = lo2_reg - qp_reg;
        if (r_reg >= PR32X2)
            p_next = 30'(r_reg - PR32X2);
        else if (r_reg >= PR32)
            p_next = 30'(r_reg - PR32);
        else
            p_next = r_reg[29:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            q_reg    <= '0;
            lo1_reg  <= '0;
            lo2_reg  <= '0;
            qp_reg   <= '0;
            r_reg    <= '0;
            p_reg    <= '0;
        end
        else if (en)
        begin
            prod_reg <= {30'd0, a} * {30'd0, b};
            q_reg    <= est[61:31];
            lo1_reg  <= prod_reg[31:0];
            qp_reg   <= {1'b0, q_reg} * PR32;
            lo2_reg  <= lo1_reg;
            r_reg    <= r_next;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;
endmodule
`default_nettype wire

[hdl/pmmp_cell.sv]
`default_nettype none
// One systolic cell: holds a_i, multiplies it by the passing b coefficient and
// adds the product into the partial sum flowing past. The b coefficients pass
// through two registers per cell while the partial sums pass through one.
module pmmp_cell
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        load_en,
    input  wire logic        clear,
    input  wire logic [29:0] a_load,
    input  wire logic [29:0] b_in,
    input  wire logic [29:0] s_in,
    output logic [29:0]      b_out,
    output logic [29:0]      s_out
);
    localparam int B_DLY = 2;

    logic [29:0] a_reg;
    logic [29:0] prod;
    logic [29:0] b_dly_reg [B_DLY];
    logic [29:0] s_reg;

    pmmp_mulmod u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .a     (a_reg),
        .b     (b_in),
        .p     (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            for (int k = 0; k < B_DLY; k++)
                b_dly_reg[k] <= '0;
            s_reg <= '0;
        end
        else
        begin
            if (load_en)
                a_reg <= a_load;
            else if (clear)
                a_reg <= '0;
            if (en)
            begin
                b_dly_reg[0] <= b_in;
                for (int k = 1; k < B_DLY; k++)
                    b_dly_reg[k] <= b_dly_reg[k-1];
                s_reg <= pmmp_pkg::reduce_once({1'b0, s_in} + {1'b0, prod});
            end
        end
    end

    assign b_out = b_dly_reg[B_DLY-1];
    assign s_out = s_reg;
endmodule
`default_nettype wire

[hdl/poly_multiply_mod_prime_core.sv]
`default_nettype none
// Polynomial product modulo 1000000009.
// Input channel (in_valid/in_ready/in_data): one beat per coefficient pair,
// lowest degree first; last_in ends the load. Beats beyond MAX_TERMS are
// dropped, though their last_in still ends the load.
// Output channel (out_valid/out_ready/out_data): 2n-1 product coefficients,
// lowest degree first, last_out on the final beat.
// The load takes one pair per cycle. After the last pair the b coefficients
// stream through a row of MAX_TERMS multiply-accumulate cells, one per cycle
// while the row advances, passing two registers per cell while the partial
// sums pass one; the results then follow one per cycle while the receiver
// keeps up. The row runs on until it is clear before the next load is taken.
// A stall on the output freezes the whole row, so no beat is lost.
// Reset empties the load and the row; no clearing pass is needed.
module poly_multiply_mod_prime_core
#(
    parameter int MAX_TERMS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pmmp_pkg::in_beat_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output pmmp_pkg::out_beat_t       out_data
);
    localparam int CW   = $clog2(MAX_TERMS + 1);
    localparam int IW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CELL_LAT = 6;
    localparam int LAT  = MAX_TERMS + CELL_LAT - 1;
    localparam int TW   = $clog2(3 * MAX_TERMS + CELL_LAT + 2);
    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;

    // Gated clock is avoided: the row simply advances on every cycle in the run
    // state when the output is free, so it only ever works in lock step.
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [TW-1:0] tick_reg, tick_next;
    logic [29:0]   b_store_reg [MAX_TERMS];
    logic [29:0]   a_in, b_in_r;
    logic          advance;
    logic          load_start;
    logic          out_valid_reg, out_valid_next;
    logic          out_last_reg, out_last_next;
    logic [29:0]   out_coef_reg;
    logic [29:0]   feed_b;
    logic [29:0]   b_chain [MAX_TERMS+1];
    logic [29:0]   s_chain [MAX_TERMS+1];
    logic [TW-1:0] first_out, last_out_t, flush_end;

    assign a_in   = pmmp_pkg::reduce_once({1'b0, in_data.coef_a});
    assign b_in_r = pmmp_pkg::reduce_once({1'b0, in_data.coef_b});
    assign in_ready = (state_reg == ST_LOAD);
    assign advance  = (state_reg == ST_RUN) && (!out_valid_reg || out_ready);
    assign load_start = in_valid && in_ready && (cnt_reg == '0);

    // b_j enters at tick j for j < n, zeros afterwards; s_k leaves the row at
    // tick k + LAT, valid for k < 2n-1.
    always_comb
    begin
        feed_b = '0;
        for (int j = 0; j < MAX_TERMS; j++)
            if (TW'(j) == tick_reg && CW'(j) < cnt_reg)
                feed_b = b_store_reg[j];
    end

    assign first_out  = TW'(LAT);
    assign last_out_t = TW'(LAT) + TW'({cnt_reg, 1'b0}) - TW'(2);
    assign flush_end  = TW'(cnt_reg) + TW'(2 * MAX_TERMS + 4);

    genvar g;
    assign b_chain[0] = feed_b;
    assign s_chain[0] = '0;
    generate
        for (g = 0; g < MAX_TERMS; g++)
        begin : g_row
            logic ld;
            assign ld = in_valid && in_ready && (cnt_reg == CW'(g));
            pmmp_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (advance),
                .load_en (ld),
                .clear   (load_start),
                .a_load  (a_in),
                .b_in    (b_chain[g]),
                .s_in    (s_chain[g]),
                .b_out   (b_chain[g+1]),
                .s_out   (s_chain[g+1])
            );
        end
    endgenerate
    // Cell g holds a_g; the first beat of a load clears the cells that the load
    // leaves unused.

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        tick_next      = tick_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (cnt_reg < CW'(MAX_TERMS))
                        cnt_next = cnt_reg + CW'(1);
                    if (in_data.last_in)
                    begin
                        state_next = ST_RUN;
                        tick_next  = '0;
                    end
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    tick_next = tick_reg + TW'(1);
                    if (tick_reg >= first_out && tick_reg <= last_out_t)
                    begin
                        out_valid_next = 1'b1;
                        out_last_next  = (tick_reg == last_out_t);
                    end
                    if (tick_reg == flush_end)
                    begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && cnt_reg < CW'(MAX_TERMS))
            b_store_reg[cnt_reg[IW-1:0]] <= b_in_r;
        if (advance)
            out_coef_reg <= s_chain[MAX_TERMS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_valid             = out_valid_reg;
    assign out_data.product_coef = out_coef_reg;
    assign out_data.last_out     = out_last_reg;
endmodule
`default_nettype wire
